>>> rtl/mbg_pkg.sv
// ----------------------------------------------------------------------------
// mbg_pkg: shared types and constants for the multibyte byte generator
// Holds the mode, sub-form, status and register index codes, the range cell
// layout and the descriptor that passes from the classifier to the serialiser.
// ----------------------------------------------------------------------------
package mbg_pkg;

  localparam int TABLE_CELLS = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_CNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL0     = 3'd2;
  localparam int CFG_DATA_W = 37;

  // encoding modes
  localparam logic [2:0] MODE_ONE   = 3'd0;
  localparam logic [2:0] MODE_TWO   = 3'd1;
  localparam logic [2:0] MODE_TABLE = 3'd2;
  localparam logic [2:0] MODE_GR    = 3'd3;
  localparam logic [2:0] MODE_SS3   = 3'd4;
  localparam logic [2:0] MODE_SS2   = 3'd5;

  // table sub-forms
  localparam logic [1:0] SUB_ONE = 2'd0;
  localparam logic [1:0] SUB_TWO = 2'd1;
  localparam logic [1:0] SUB_GR  = 2'd2;
  localparam logic [1:0] SUB_SS2 = 2'd3;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ROOM    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  localparam logic [7:0] BYTE_SS2 = 8'h8E;
  localparam logic [7:0] BYTE_SS3 = 8'h8F;
  localparam logic [7:0] BYTE_A2  = 8'hA2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] subform;
    logic [2:0] need;
    logic [7:0] maxh;
    logic [7:0] minh;
    logic [7:0] maxl;
    logic [7:0] minl;
  } cell_t;

  // one classified item: its bytes, index of the final byte, status
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      status;
  } desc_t;

  // queue head as seen by the serialiser
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } qhead_t;

  function automatic logic [7:0] gr(input logic [7:0] b);
    gr = b | 8'h80;
  endfunction

endpackage

>>> rtl/mbg_front.sv
// ----------------------------------------------------------------------------
// mbg_front: configuration registers and item classifier
// Turns a character code and free room into a descriptor of up to four bytes,
// or a single failure result.
// ----------------------------------------------------------------------------
module mbg_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]                    char_code,
  input  logic [15:0]                    room,
  output mbg_pkg::desc_t                 desc
);
  import mbg_pkg::*;

  logic [2:0] mode_r;
  logic [2:0] cell_cnt_r;
  cell_t      cells_r [TABLE_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ONE;
      cell_cnt_r <= '0;
      for (int k = 0; k < TABLE_CELLS; k++) begin
        cells_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_wdata[2:0];
      end
      if (cfg_index == CFG_CELL_CNT) begin
        cell_cnt_r <= cfg_wdata[2:0];
      end
      for (int k = 0; k < TABLE_CELLS; k++) begin
        if (cfg_index == CFG_CELL0 + CFG_IDX_W'(k)) begin
          cells_r[k] <= cell_t'(cfg_wdata);
        end
      end
    end
  end

  logic [7:0] hi, lo;
  logic [TABLE_CELLS-1:0] hit;
  logic       found;
  cell_t      sel;

  assign hi = char_code[15:8];
  assign lo = char_code[7:0];

  // every cell compares in parallel; a clamped count simply enables the first cells
  always_comb begin
    for (int k = 0; k < TABLE_CELLS; k++) begin
      hit[k] = (3'(k) < cell_cnt_r)
            && lo >= cells_r[k].minl && lo <= cells_r[k].maxl
            && hi >= cells_r[k].minh && hi <= cells_r[k].maxh;
    end
  end

  // first matching cell wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < TABLE_CELLS; k++) begin
      if (hit[k] && !found) begin
        found = 1'b1;
        sel   = cells_r[k];
      end
    end
  end

  always_comb begin
    desc = '0;
    unique case (mode_r)
      MODE_ONE: begin
        desc.bytes[0] = lo;
      end
      MODE_TWO: begin
        if (room < 16'd2) begin
          desc.status = ST_ROOM;
        end else begin
          desc.bytes[0] = hi;
          desc.bytes[1] = lo;
          desc.last_idx = 2'd1;
        end
      end
      MODE_GR: begin
        if (room < 16'd2) begin
          desc.status = ST_ROOM;
        end else begin
          desc.bytes[0] = gr(hi);
          desc.bytes[1] = gr(lo);
          desc.last_idx = 2'd1;
        end
      end
      MODE_SS3: begin
        if (room < 16'd3) begin
          desc.status = ST_ROOM;
        end else begin
          desc.bytes[0] = BYTE_SS3;
          desc.bytes[1] = gr(hi);
          desc.bytes[2] = gr(lo);
          desc.last_idx = 2'd2;
        end
      end
      MODE_SS2: begin
        if (room < 16'd4) begin
          desc.status = ST_ROOM;
        end else begin
          desc.bytes[0] = BYTE_SS2;
          desc.bytes[1] = BYTE_A2;
          desc.bytes[2] = gr(hi);
          desc.bytes[3] = gr(lo);
          desc.last_idx = 2'd3;
        end
      end
      MODE_TABLE: begin
        if (!found) begin
          desc.status = ST_NOMATCH;
        end else if (room < {13'd0, sel.need}) begin
          desc.status = ST_ROOM;
        end else begin
          unique case (sel.subform)
            SUB_ONE: begin
              desc.bytes[0] = lo;
            end
            SUB_TWO: begin
              desc.bytes[0] = hi;
              desc.bytes[1] = lo;
              desc.last_idx = 2'd1;
            end
            SUB_GR: begin
              desc.bytes[0] = gr(hi);
              desc.bytes[1] = gr(lo);
              desc.last_idx = 2'd1;
            end
            SUB_SS2: begin
              desc.bytes[0] = BYTE_SS2;
              desc.bytes[1] = lo;
              desc.last_idx = 2'd1;
            end
            default: ;
          endcase
        end
      end
      default: begin
        desc.status = ST_NOMATCH;
      end
    endcase
  end

endmodule

>>> rtl/mbg_queue.sv
// ----------------------------------------------------------------------------
// mbg_queue: descriptor queue
// Small circular buffer between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module mbg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbg_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output mbg_pkg::qhead_t head
);
  import mbg_pkg::*;

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.desc  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> rtl/mbg_back.sv
// ----------------------------------------------------------------------------
// mbg_back: byte serialiser
// Holds one descriptor and hands out its bytes one per accepted result.
// ----------------------------------------------------------------------------
module mbg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mbg_pkg::qhead_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      byte_index,
  output logic            last,
  output logic [1:0]      status
);
  import mbg_pkg::*;

  desc_t      desc_r, desc_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       taken, at_last;

  assign taken   = busy_r && !out_stall;
  assign at_last = (idx_r == desc_r.last_idx);

  // reload straight after the final byte goes, so short items follow back to back
  always_comb begin
    desc_nxt = desc_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    pop      = 1'b0;
    if (!busy_r || (taken && at_last)) begin
      pop      = head.valid;
      busy_nxt = head.valid;
      desc_nxt = head.desc;
      idx_nxt  = '0;
    end else if (taken) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  assign out_valid  = busy_r;
  assign out_byte   = desc_r.bytes[idx_r];
  assign byte_index = idx_r;
  assign last       = at_last;
  assign status     = desc_r.status;

endmodule

>>> rtl/multibyte_charset_byte_generator.sv
// An accepted item is written into the descriptor queue and then loaded into the
//   serialiser register, which puts its first byte on the port.
// Throughput: the serialiser gives one byte per cycle while out_stall is low; an item
//   has 1 to 4 bytes (1 for one-byte forms and failures, 4 for the 8E A2 form).
// The four-entry descriptor queue keeps accepting while the output is stalled, until full.
// Reset: synchronous, active low; clears the queue, the serialiser and every
//   configuration register (mode one-byte, no table cells).
// ----------------------------------------------------------------------------
// multibyte_charset_byte_generator: EUC-style multibyte encoder
// Front classifier, descriptor queue and byte serialiser.
// ----------------------------------------------------------------------------
module multibyte_charset_byte_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_char_code,
  input  logic [15:0]                    in_room,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_out_byte,
  output logic [1:0]                     out_byte_index,
  output logic                           out_last,
  output logic [1:0]                     out_status
);
  import mbg_pkg::*;

  desc_t  front_desc;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;

  // classification is combinational on the incoming item; the queue register
  // is the only stage between front and back
  mbg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .char_code (in_char_code),
    .room      (in_room),
    .desc      (front_desc)
  );

  // stall depends only on queue fill, never on the output side directly
  assign in_stall = q_full;

  mbg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_desc (front_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // serialiser: one byte per accepted result, last byte flagged
  mbg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_out_byte),
    .byte_index (out_byte_index),
    .last       (out_last),
    .status     (out_status)
  );

endmodule

>>> rtl/mbg_checker.sv
// ----------------------------------------------------------------------------
// mbg_checker: port-level checks for the multibyte byte generator
// Watches the result channel for sequencing and failure-result shape.
// ----------------------------------------------------------------------------
module mbg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_out_byte,
  input logic [1:0] out_byte_index,
  input logic       out_last,
  input logic [1:0] out_status
);
  import mbg_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte)
      && $stable(out_byte_index) && $stable(out_last) && $stable(out_status))
    else $error("stalled result changed");

  // a failure is a single zero byte at index 0
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_byte_index == 2'd0
      && out_out_byte == 8'd0)
    else $error("malformed failure result");

  // bytes of one item follow without a gap, index counting up
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid
      && out_byte_index == $past(out_byte_index) + 2'd1)
    else $error("broken byte sequence");

  // after reset nothing is offered
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multibyte_charset_byte_generator mbg_checker u_mbg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_out_byte   (out_out_byte),
  .out_byte_index (out_byte_index),
  .out_last       (out_last),
  .out_status     (out_status)
);

>>> dv/tb_multibyte_charset_byte_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multibyte_charset_byte_generator: self-checking bench for the encoder
// Drives character items through a directed table and then through random
// phases, one register setting per phase, with random gaps on both channels (none in the calm phase).
// Each byte that leaves the block is checked against an in-bench encoder.
// ----------------------------------------------------------------------------
module tb_multibyte_charset_byte_generator;
  import mbg_pkg::*;

  // modes the block leaves undefined: both must fail with no match
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam logic [7:0] GR_BIT = 8'h80;
  localparam int IDLE_PCT = 21;
  localparam int TIMEOUT_NS = 200000;

  // one byte as the result channel presents it
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_index;
    logic       last;
    logic [1:0] status;
  } byte_res_t;

  // one character item; typed rows carry their single expected byte inline
  typedef struct packed {
    logic [15:0] code;
    logic [15:0] room;
    logic        typed;
    logic [7:0]  t_byte;
    logic [1:0]  t_status;
  } char_item_t;

  // directed row: register setting it needs, then the item
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  cnt;
    logic [15:0] code;
    logic [15:0] room;
    logic        typed;
    logic [7:0]  t_byte;
    logic [1:0]  t_status;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [15:0]           in_char_code = '0;
  logic [15:0]           in_room = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_out_byte;
  logic [1:0]            out_byte_index;
  logic                  out_last;
  logic [1:0]            out_status;

  // shadow of the register file, updated as each write goes in
  logic [2:0] cur_mode = MODE_ONE;
  logic [2:0] cur_count = 3'd0;
  cell_t      cur_cells [TABLE_CELLS];
  // cells to be loaded by the next setup
  cell_t      plan_cells [TABLE_CELLS];

  char_item_t char_queue [$];     // items waiting to be driven
  byte_res_t  expected_bytes [$]; // bytes owed by accepted items
  char_item_t cur_item;           // item currently on the input port
  byte_res_t  want, got;
  int         faults = 0;
  bit         calm = 1'b0;        // no gaps on either side while set

  // Directed table. Typed rows are those whose single result is plain:
  // reset setting, room shortfalls, no match and the undefined modes.
  // The table cells are the fixed set loaded in the initial block.
  dir_row_t directed_rows [24] = '{
    // reset setting: one byte, low byte only, room ignored
    '{MODE_ONE,   3'd0, 16'h0000, 16'd0,     1'b1, 8'h00, ST_OK},
    '{MODE_ONE,   3'd0, 16'hFFFF, 16'd0,     1'b1, 8'hFF, ST_OK},
    '{MODE_TWO,   3'd0, 16'h1234, 16'd2,     1'b0, 8'h00, ST_OK},
    '{MODE_TWO,   3'd0, 16'hFFFF, 16'd1,     1'b1, 8'h00, ST_ROOM},
    '{MODE_TWO,   3'd0, 16'h0000, 16'hFFFF,  1'b0, 8'h00, ST_OK},
    '{MODE_GR,    3'd0, 16'h0000, 16'd2,     1'b0, 8'h00, ST_OK},
    '{MODE_GR,    3'd0, 16'h1234, 16'd1,     1'b1, 8'h00, ST_ROOM},
    '{MODE_SS3,   3'd0, 16'h7F01, 16'd3,     1'b0, 8'h00, ST_OK},
    '{MODE_SS3,   3'd0, 16'hFFFF, 16'd2,     1'b1, 8'h00, ST_ROOM},
    '{MODE_SS2,   3'd0, 16'h0000, 16'd4,     1'b0, 8'h00, ST_OK},
    '{MODE_SS2,   3'd0, 16'hFFFF, 16'd3,     1'b1, 8'h00, ST_ROOM},
    '{MODE_RSVD6, 3'd0, 16'h1234, 16'hFFFF,  1'b1, 8'h00, ST_NOMATCH},
    '{MODE_RSVD7, 3'd0, 16'h0000, 16'd0,     1'b1, 8'h00, ST_NOMATCH},
    // table with no cells in use never matches
    '{MODE_TABLE, 3'd0, 16'h0041, 16'd10,    1'b1, 8'h00, ST_NOMATCH},
    '{MODE_TABLE, 3'd5, 16'h0041, 16'd1,     1'b0, 8'h00, ST_OK},
    '{MODE_TABLE, 3'd5, 16'h0041, 16'd0,     1'b1, 8'h00, ST_ROOM},
    '{MODE_TABLE, 3'd5, 16'hB0C0, 16'd2,     1'b0, 8'h00, ST_OK},
    // room field of 7 but only two bytes go out
    '{MODE_TABLE, 3'd5, 16'h8512, 16'd7,     1'b0, 8'h00, ST_OK},
    '{MODE_TABLE, 3'd5, 16'h8512, 16'd6,     1'b1, 8'h00, ST_ROOM},
    '{MODE_TABLE, 3'd5, 16'h3345, 16'd2,     1'b0, 8'h00, ST_OK},
    // low byte lies between the bounds of the inverted (empty) cell
    '{MODE_TABLE, 3'd5, 16'hC045, 16'd0,     1'b1, 8'h00, ST_NOMATCH},
    '{MODE_TABLE, 3'd5, 16'hFFFF, 16'hFFFF,  1'b1, 8'h00, ST_NOMATCH},
    // count above the cell total scans all six; last cell catches all
    '{MODE_TABLE, 3'd7, 16'hFFFF, 16'd0,     1'b0, 8'h00, ST_OK},
    '{MODE_TABLE, 3'd6, 16'hC045, 16'd0,     1'b0, 8'h00, ST_OK}
  };

  logic [2:0] phase_modes [11] = '{
    MODE_TABLE, MODE_ONE, MODE_TWO, MODE_GR, MODE_SS3, MODE_SS2,
    MODE_TABLE, MODE_RSVD6, MODE_TABLE, MODE_RSVD7, MODE_TABLE
  };

  multibyte_charset_byte_generator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_room        (in_room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  always #1 clk = ~clk;

  function automatic void push_byte(input logic [7:0] b, input logic [1:0] idx,
                                    input logic last, input logic [1:0] st);
    byte_res_t r;
    r.out_byte = b;
    r.byte_index = idx;
    r.last = last;
    r.status = st;
    expected_bytes.push_back(r);
  endfunction

  // Works out the bytes one character gives under the current registers.
  function automatic void encode_char(input logic [15:0] code, input logic [15:0] room);
    logic [7:0] hi, lo;
    logic [7:0] b [4];
    int         n;
    int         scan;
    logic [1:0] st;
    logic       hit;
    cell_t      c;
    hi = code[15:8];
    lo = code[7:0];
    n = 0;
    st = ST_OK;
    hit = 1'b0;
    case (cur_mode)
      MODE_ONE: begin
        b[0] = lo;
        n = 1;
      end
      MODE_TWO: begin
        if (room < 2) st = ST_ROOM;
        else begin
          b[0] = hi; b[1] = lo; n = 2;
        end
      end
      MODE_GR: begin
        if (room < 2) st = ST_ROOM;
        else begin
          b[0] = hi | GR_BIT; b[1] = lo | GR_BIT; n = 2;
        end
      end
      MODE_SS3: begin
        if (room < 3) st = ST_ROOM;
        else begin
          b[0] = BYTE_SS3; b[1] = hi | GR_BIT; b[2] = lo | GR_BIT; n = 3;
        end
      end
      MODE_SS2: begin
        if (room < 4) st = ST_ROOM;
        else begin
          b[0] = BYTE_SS2; b[1] = BYTE_A2; b[2] = hi | GR_BIT; b[3] = lo | GR_BIT;
          n = 4;
        end
      end
      MODE_TABLE: begin
        // first cell holding both bytes wins; an inverted range holds nothing
        scan = (cur_count > TABLE_CELLS) ? TABLE_CELLS : cur_count;
        st = ST_NOMATCH;
        for (int k = 0; k < scan && !hit; k++) begin
          c = cur_cells[k];
          if (lo >= c.minl && lo <= c.maxl && hi >= c.minh && hi <= c.maxh) begin
            hit = 1'b1;
            if (room < c.need) st = ST_ROOM;
            else begin
              st = ST_OK;
              case (c.subform)
                SUB_ONE: begin b[0] = lo; n = 1; end
                SUB_TWO: begin b[0] = hi; b[1] = lo; n = 2; end
                SUB_GR:  begin b[0] = hi | GR_BIT; b[1] = lo | GR_BIT; n = 2; end
                default: begin b[0] = BYTE_SS2; b[1] = lo; n = 2; end
              endcase
            end
          end
        end
      end
      default: st = ST_NOMATCH;
    endcase
    if (st != ST_OK) push_byte(8'h00, 2'd0, 1'b1, st);
    else
      for (int k = 0; k < n; k++) push_byte(b[k], 2'(k), k == n - 1, ST_OK);
  endfunction

  // Mostly proper ranges; now and then all zeros, all ones or an inverted range.
  function automatic cell_t rand_cell();
    cell_t c;
    int    sel;
    sel = $urandom_range(0, 9);
    c.minl = 8'($urandom_range(0, 255));
    c.maxl = 8'($urandom_range(c.minl, 255));
    c.minh = 8'($urandom_range(0, 255));
    c.maxh = 8'($urandom_range(c.minh, 255));
    c.need = 3'($urandom_range(0, 7));
    c.subform = 2'($urandom_range(0, 3));
    if (sel == 0) c = '0;
    else if (sel == 1) c = '1;
    else if (sel == 2) begin
      c.minl = 8'($urandom_range(1, 255));
      c.maxl = 8'($urandom_range(0, c.minl - 1));
    end
    return c;
  endfunction

  // One register write; the caller lowers cfg_we after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_MODE) cur_mode = data[2:0];
    else if (idx == CFG_CELL_CNT) cur_count = data[2:0];
    else cur_cells[idx - CFG_CELL0] = data;
  endtask

  // Loads mode, count and the planned cells; returns on a falling edge.
  task automatic load_setup(input logic [2:0] m, input logic [2:0] cnt);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_CELL_CNT, CFG_DATA_W'(cnt));
    for (int k = 0; k < TABLE_CELLS; k++)
      write_reg(CFG_CELL0 + CFG_IDX_W'(k), plan_cells[k]);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Every item sent and every byte in; state is read at falling edges only.
  task automatic wait_idle();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Both channels. Bytes out are checked before the item accepted at the
  // same edge adds its own, so ordering inside the edge cannot matter.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.out_byte = out_out_byte;
        got.byte_index = out_byte_index;
        got.last = out_last;
        got.status = out_status;
        if (expected_bytes.size() == 0) begin
          if (faults < 10)
            $display("unexpected byte %02h idx %0d last %0b status %0d",
                     got.out_byte, got.byte_index, got.last, got.status);
          faults++;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            if (faults < 10)
              $display({"mismatch: expected byte %02h idx %0d last %0b status %0d,",
                        " got %02h %0d %0b %0d"},
                       want.out_byte, want.byte_index, want.last, want.status,
                       got.out_byte, got.byte_index, got.last, got.status);
            faults++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cur_item.typed) push_byte(cur_item.t_byte, 2'd0, 1'b1, cur_item.t_status);
        else encode_char(cur_item.code, cur_item.room);
      end
      // port is free once empty or just taken; a gap is a dice roll
      if (!in_valid || !in_stall) begin
        if (char_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item = char_queue.pop_front();
          in_valid <= 1'b1;
          in_char_code <= cur_item.code;
          in_room <= cur_item.room;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    char_item_t it;
    cell_t      c;
    logic [2:0] m, cnt;
    logic [7:0] hi, lo;
    int         tbl, n, scan, k;
    for (int i = 0; i < TABLE_CELLS; i++) cur_cells[i] = '0;
    // fixed cells for the directed rows: ASCII, empty, GR block,
    // 8E block asking more room than it uses, plain block, catch-all
    plan_cells[0] = '{SUB_ONE, 3'd1, 8'h00, 8'h00, 8'h7F, 8'h20};
    plan_cells[1] = '{SUB_TWO, 3'd0, 8'hFF, 8'h00, 8'h40, 8'h50};
    plan_cells[2] = '{SUB_GR,  3'd2, 8'hFE, 8'hA1, 8'hFE, 8'hA1};
    plan_cells[3] = '{SUB_SS2, 3'd7, 8'h8F, 8'h80, 8'hFF, 8'h00};
    plan_cells[4] = '{SUB_TWO, 3'd2, 8'h3F, 8'h30, 8'hFF, 8'h00};
    plan_cells[5] = '{SUB_ONE, 3'd0, 8'hFF, 8'h00, 8'hFF, 8'h00};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part: first rows run on the reset setting untouched
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode || directed_rows[i].cnt != cur_count) begin
        wait_idle();
        load_setup(directed_rows[i].mode, directed_rows[i].cnt);
      end
      it.code = directed_rows[i].code;
      it.room = directed_rows[i].room;
      it.typed = directed_rows[i].typed;
      it.t_byte = directed_rows[i].t_byte;
      it.t_status = directed_rows[i].t_status;
      char_queue.push_back(it);
    end

    // random phases; table phases are longer and mostly aim inside a cell
    tbl = 0;
    for (int p = 0; p < 11; p++) begin
      m = phase_modes[p];
      if (m == MODE_TABLE) begin
        cnt = (tbl == 0) ? 3'd6 : (tbl == 1) ? 3'd7 : 3'($urandom_range(1, 5));
        tbl++;
        n = 30;
      end else begin
        cnt = 3'($urandom_range(0, 7));
        n = 15;
      end
      for (int i = 0; i < TABLE_CELLS; i++) plan_cells[i] = rand_cell();
      wait_idle();
      calm = (p == 6);
      load_setup(m, cnt);
      scan = (cur_count > TABLE_CELLS) ? TABLE_CELLS : cur_count;
      for (int i = 0; i < n; i++) begin
        it = '0;
        it.code = 16'($urandom_range(0, 65535));
        if (m == MODE_TABLE && scan > 0 && $urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, scan - 1);
          c = cur_cells[k];
          lo = (c.minl <= c.maxl) ? 8'($urandom_range(c.minl, c.maxl)) : it.code[7:0];
          hi = (c.minh <= c.maxh) ? 8'($urandom_range(c.minh, c.maxh)) : it.code[15:8];
          it.code = {hi, lo};
        end
        // small room sits around every threshold; full range toggles all bits
        it.room = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 8))
                                             : 16'($urandom_range(0, 65535));
        char_queue.push_back(it);
      end
    end

    wait_idle();
    calm = 1'b0;
    repeat (10) @(negedge clk);
    if (faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mbg_pkg.sv
rtl/mbg_front.sv
rtl/mbg_queue.sv
rtl/mbg_back.sv
rtl/multibyte_charset_byte_generator.sv
rtl/mbg_checker.sv
dv/tb_multibyte_charset_byte_generator.sv
